FILE: src/rssc_pkg.sv
package rssc_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 8;

    localparam logic [15:0] SAMPLE_TICKS_RESET = 16'd50;
    localparam logic [15:0] PULSE_TICKS_RESET  = 16'd100;
    localparam logic [3:0]  MAX_ERRORS_RESET   = 4'd3;
    localparam logic [3:0]  MISS_COUNT_MAX     = 4'd15;

    localparam int SPEED_W     = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SAMPLE_TICKS = 2'd0,
        CFG_PULSE_TICKS  = 2'd1,
        CFG_MAX_ERRORS   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        MOVE_NONE      = 2'd0,
        MOVE_REACHED   = 2'd1,
        MOVE_ABANDONED = 2'd2
    } move_status_t;

    typedef enum logic [1:0] {
        REQ_NONE    = 2'd0,
        REQ_QUEUED  = 2'd1,
        REQ_IGNORED = 2'd2,
        REQ_DROPPED = 2'd3
    } request_status_t;

    typedef struct packed {
        logic [7:0] requested_speed;
        logic       led_high;
        logic       led_mid;
        logic       led_low;
    } item_data_t;

    typedef struct packed {
        logic       action;
        item_data_t data;
    } item_t;

    typedef struct packed {
        request_status_t    request_status;
        move_status_t       move_status;
        logic               speed_reported;
        logic [SPEED_W-1:0] current_speed;
        logic               relay_level;
    } result_t;

    typedef struct packed {
        logic [15:0] sample_ticks;
        logic [15:0] pulse_ticks;
        logic [3:0]  max_errors;
    } cfg_t;

    function automatic logic [SPEED_W-1:0] led_speed(input item_data_t d);
        logic [SPEED_W-1:0] s;
        s = 2'd0;
        if (!d.led_low)  s = 2'd1;
        if (!d.led_mid)  s = 2'd2;
        if (!d.led_high) s = 2'd3;
        return s;
    endfunction

    function automatic logic [SPEED_W-1:0] speed_after(input logic [SPEED_W-1:0] s);
        return SPEED_W'(s + 2'd1);
    endfunction

endpackage

FILE: src/rssc_ram.sv
module rssc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/rssc_core.sv
module rssc_core #(
    parameter int QUEUE_DEPTH = rssc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              proc_en,
    input  rssc_pkg::item_t   item,
    input  rssc_pkg::cfg_t    cfg,
    output rssc_pkg::result_t result
);
    import rssc_pkg::*;

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    phase_t             phase_reg, phase_next;
    logic [15:0]        tick_timer_reg, tick_timer_next;
    logic [SPEED_W-1:0] target_speed_reg, target_speed_next;
    logic [SPEED_W-1:0] expected_speed_reg, expected_speed_next;
    logic [3:0]         miss_count_reg, miss_count_next;
    logic [SPEED_W-1:0] last_raw_speed_reg, last_raw_speed_next;
    logic [SPEED_W-1:0] confirmed_speed_reg, confirmed_speed_next;
    logic [IDX_W-1:0]   queue_head_reg, queue_head_next;
    logic [IDX_W-1:0]   queue_tail_reg, queue_tail_next;
    logic [FILL_W-1:0]  queue_fill_reg, queue_fill_next;
    logic               bypass_valid_reg;
    logic [SPEED_W-1:0] bypass_data_reg;

    logic               q_wr_en;
    logic [IDX_W-1:0]   q_rd_addr;
    logic [SPEED_W-1:0] q_rd_data;
    logic [SPEED_W-1:0] head_entry;
    logic [SPEED_W-1:0] raw;
    logic [SPEED_W-1:0] req_speed;
    logic [16:0]        timer_inc;
    logic               do_sample;
    logic               started;
    logic               reported;
    move_status_t       move;
    request_status_t    req;

    rssc_ram #(
        .WIDTH(SPEED_W),
        .DEPTH(QUEUE_DEPTH),
        .ADDR_W(IDX_W)
    ) u_queue (
        .aclk   (aclk),
        .wr_en  (q_wr_en),
        .wr_addr(queue_tail_reg),
        .wr_data(req_speed),
        .rd_addr(q_rd_addr),
        .rd_data(q_rd_data)
    );

    // The queue memory is read ahead at the next head position; a write to that
    // same entry in the same cycle is forwarded.
    assign q_rd_addr  = queue_head_next;
    assign head_entry = bypass_valid_reg ? bypass_data_reg : q_rd_data;

    assign raw       = led_speed(item.data);
    assign req_speed = (|item.data.requested_speed[7:2]) ? 2'd3
                                                         : item.data.requested_speed[1:0];
    assign timer_inc = {1'b0, tick_timer_reg} + 17'd1;

    always_comb begin
        phase_next           = phase_reg;
        tick_timer_next      = tick_timer_reg;
        target_speed_next    = target_speed_reg;
        expected_speed_next  = expected_speed_reg;
        miss_count_next      = miss_count_reg;
        last_raw_speed_next  = last_raw_speed_reg;
        confirmed_speed_next = confirmed_speed_reg;
        queue_head_next      = queue_head_reg;
        queue_tail_next      = queue_tail_reg;
        queue_fill_next      = queue_fill_reg;
        q_wr_en              = 1'b0;
        do_sample            = 1'b0;
        started              = 1'b0;
        reported             = 1'b0;
        move                 = MOVE_NONE;
        req                  = REQ_NONE;

        if (proc_en) begin
            if (item.action) begin
                if (req_speed == confirmed_speed_reg) begin
                    req = REQ_IGNORED;
                end else if (queue_fill_reg == FILL_W'(QUEUE_DEPTH)) begin
                    req = REQ_DROPPED;
                end else begin
                    q_wr_en         = 1'b1;
                    queue_tail_next = (queue_tail_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                      : IDX_W'(queue_tail_reg + 1'b1);
                    queue_fill_next = FILL_W'(queue_fill_reg + 1'b1);
                    req             = REQ_QUEUED;
                end
            end else begin
                case (phase_reg)
                    PH_HIGH: begin
                        if (tick_timer_reg >= cfg.pulse_ticks) begin
                            phase_next      = PH_LOW;
                            tick_timer_next = 16'd1;
                        end else begin
                            tick_timer_next = timer_inc[15:0];
                        end
                    end
                    PH_LOW: begin
                        if (tick_timer_reg < cfg.pulse_ticks) begin
                            tick_timer_next = timer_inc[15:0];
                        end else begin
                            if (raw == expected_speed_reg) begin
                                expected_speed_next = speed_after(raw);
                            end else if (miss_count_reg != MISS_COUNT_MAX) begin
                                miss_count_next = 4'(miss_count_reg + 4'd1);
                            end
                            if (raw == target_speed_reg || miss_count_next >= cfg.max_errors) begin
                                move            = (raw == target_speed_reg) ? MOVE_REACHED
                                                                            : MOVE_ABANDONED;
                                phase_next      = PH_IDLE;
                                do_sample       = 1'b1;
                                tick_timer_next = (cfg.sample_ticks <= 16'd1) ? 16'd0 : 16'd1;
                            end else begin
                                phase_next      = PH_HIGH;
                                tick_timer_next = 16'd1;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        if (tick_timer_reg == 16'd0) begin
                            if (queue_fill_reg != '0) begin
                                queue_head_next = (queue_head_reg == IDX_W'(QUEUE_DEPTH - 1))
                                                  ? '0 : IDX_W'(queue_head_reg + 1'b1);
                                queue_fill_next = FILL_W'(queue_fill_reg - 1'b1);
                                if (head_entry != confirmed_speed_reg) begin
                                    target_speed_next   = head_entry;
                                    expected_speed_next = speed_after(raw);
                                    miss_count_next     = 4'd0;
                                    phase_next          = PH_HIGH;
                                    tick_timer_next     = 16'd1;
                                    started             = 1'b1;
                                end
                            end
                            do_sample = !started;
                        end
                        if (!started) begin
                            tick_timer_next = (timer_inc >= {1'b0, cfg.sample_ticks}) ? 16'd0
                                              : timer_inc[15:0];
                        end
                    end
                endcase

                if (do_sample) begin
                    if (last_raw_speed_reg != raw) begin
                        last_raw_speed_next = raw;
                    end else if (raw != confirmed_speed_reg) begin
                        confirmed_speed_next = raw;
                        reported             = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_IDLE;
            tick_timer_reg      <= '0;
            target_speed_reg    <= '0;
            expected_speed_reg  <= '0;
            miss_count_reg      <= '0;
            last_raw_speed_reg  <= '0;
            confirmed_speed_reg <= '0;
            queue_head_reg      <= '0;
            queue_tail_reg      <= '0;
            queue_fill_reg      <= '0;
            bypass_valid_reg    <= 1'b0;
        end else begin
            phase_reg           <= phase_next;
            tick_timer_reg      <= tick_timer_next;
            target_speed_reg    <= target_speed_next;
            expected_speed_reg  <= expected_speed_next;
            miss_count_reg      <= miss_count_next;
            last_raw_speed_reg  <= last_raw_speed_next;
            confirmed_speed_reg <= confirmed_speed_next;
            queue_head_reg      <= queue_head_next;
            queue_tail_reg      <= queue_tail_next;
            queue_fill_reg      <= queue_fill_next;
            bypass_valid_reg    <= q_wr_en && (queue_tail_reg == q_rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        bypass_data_reg <= req_speed;
    end

    always_comb begin
        result.relay_level    = (phase_next == PH_HIGH);
        result.current_speed  = confirmed_speed_next;
        result.speed_reported = reported;
        result.move_status    = move;
        result.request_status = req;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        queue_fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("Request queue fill exceeds its depth.");

    a_empty_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        queue_fill_reg == '0 |-> queue_head_reg == queue_tail_reg)
        else $error("Empty request queue has head and tail apart.");

    a_pulse_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HIGH || phase_reg == PH_LOW) |-> tick_timer_reg != 16'd0)
        else $error("Pulse timer is zero during a relay pulse.");

    a_move_ends_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_en && move != MOVE_NONE |-> phase_next == PH_IDLE && !result.relay_level)
        else $error("Move finished without returning to idle.");

    a_queued_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_en && req == REQ_QUEUED |=>
            queue_fill_reg == FILL_W'($past(queue_fill_reg) + 1'b1))
        else $error("Queued request did not raise the fill count.");
`endif

endmodule

FILE: src/relay_step_speed_controller_top.sv
// Relay step speed controller. Each input transfer is either a time tick that carries the
// three active-low speed indicator levels (s_tuser = 0) or a speed request (s_tuser = 1);
// every input transfer produces exactly one result transfer with the relay drive level,
// the confirmed speed and the move and request status. A new item is taken every clock
// cycle unless the result side stalls; a result passes through the input register, then
// the result register, with the controller state updated in between. Requests wait in
// a queue of QUEUE_DEPTH entries held in a small RAM. The user must write timing registers
// through the configuration port only with no item in flight; the block does not enforce it.
module relay_step_speed_controller_top #(
    parameter int QUEUE_DEPTH = rssc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // led_low, led_mid, led_high, requested_speed[7:0], zero fill
    input  logic [15:0]                      s_tdata,
    // action
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // relay_level, current_speed[1:0], speed_reported, move_status[1:0],
    // request_status[1:0]
    output logic [7:0]                       m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [rssc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rssc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import rssc_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    cfg_t    cfg_reg;
    result_t core_result;
    logic    advance;
    logic    proc_en;

    assign advance  = !out_valid_reg || m_tready;
    assign proc_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.action <= s_tuser;
            in_item_reg.data   <= s_tdata[$bits(item_data_t)-1:0];
        end
        if (proc_en) begin
            out_result_reg <= core_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_ticks <= SAMPLE_TICKS_RESET;
            cfg_reg.pulse_ticks  <= PULSE_TICKS_RESET;
            cfg_reg.max_errors   <= MAX_ERRORS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SAMPLE_TICKS: cfg_reg.sample_ticks <= cfg_wdata;
                CFG_PULSE_TICKS:  cfg_reg.pulse_ticks  <= cfg_wdata;
                CFG_MAX_ERRORS:   cfg_reg.max_errors   <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    rssc_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .proc_en(proc_en),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_result_reg;

endmodule

FILE: dv/tb_relay_step_speed_controller_top.sv
module tb_relay_step_speed_controller_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rssc_pkg::*;

    localparam int MODE_RX_STALLS = 0;
    localparam int MODE_TX_GAPS   = 1;
    localparam int MODE_FREE      = 2;

    typedef struct packed {
        phase_t          phase;
        logic [15:0]     timer;
        logic [1:0]      target;
        logic [1:0]      next_due;
        logic [3:0]      misses;
        logic [1:0]      last_raw;
        logic [1:0]      confirmed;
        logic [7:0][1:0] fifo;
        logic [2:0]      head;
        logic [2:0]      tail;
        logic [3:0]      fill;
        cfg_t            cfg;
    } fan_ctrl_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [7:0]             m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    fan_ctrl_t live_ctrl;
    fan_ctrl_t plan_ctrl;
    logic [1:0] fan_speed;
    int traffic_mode = MODE_RX_STALLS;
    int mismatches = 0;
    item_t items_waiting[$];
    result_t results_due[$];
    item_t item_on_bus;
    result_t seen_result;
    result_t due_result;

    relay_step_speed_controller_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH_DEFAULT)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    function automatic fan_ctrl_t ctrl_after_reset();
        fan_ctrl_t st;
        st = '0;
        st.phase = PH_IDLE;
        st.cfg.sample_ticks = SAMPLE_TICKS_RESET;
        st.cfg.pulse_ticks = PULSE_TICKS_RESET;
        st.cfg.max_errors = MAX_ERRORS_RESET;
        return st;
    endfunction

    // A speed counts as confirmed once two samples in a row agree.
    function automatic logic confirm_speed(inout fan_ctrl_t st, input logic [1:0] raw);
        if (st.last_raw != raw) begin
            st.last_raw = raw;
        end else if (raw != st.confirmed) begin
            st.confirmed = raw;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_t fan_ctrl_step(inout fan_ctrl_t st, input item_t it);
        result_t r;
        logic [1:0] raw;
        logic [1:0] want;
        logic started;
        r = '0;
        r.move_status = MOVE_NONE;
        r.request_status = REQ_NONE;
        raw = 2'd0;
        if (!it.data.led_low) raw = 2'd1;
        if (!it.data.led_mid) raw = 2'd2;
        if (!it.data.led_high) raw = 2'd3;
        if (it.action) begin
            want = (it.data.requested_speed > 8'd3) ? 2'd3 : it.data.requested_speed[1:0];
            if (want == st.confirmed) begin
                r.request_status = REQ_IGNORED;
            end else if (st.fill >= 4'(QUEUE_DEPTH_DEFAULT)) begin
                r.request_status = REQ_DROPPED;
            end else begin
                st.fifo[st.tail] = want;
                st.tail = st.tail + 3'd1;
                st.fill = st.fill + 4'd1;
                r.request_status = REQ_QUEUED;
            end
        end else if (st.phase == PH_HIGH) begin
            if (st.timer >= st.cfg.pulse_ticks) begin
                st.phase = PH_LOW;
                st.timer = 16'd1;
            end else begin
                st.timer = st.timer + 16'd1;
            end
        end else if (st.phase == PH_LOW) begin
            if (st.timer < st.cfg.pulse_ticks) begin
                st.timer = st.timer + 16'd1;
            end else begin
                if (raw == st.next_due) begin
                    st.next_due = raw + 2'd1;
                end else if (st.misses != MISS_COUNT_MAX) begin
                    st.misses = st.misses + 4'd1;
                end
                if (raw == st.target || st.misses >= st.cfg.max_errors) begin
                    r.move_status = (raw == st.target) ? MOVE_REACHED : MOVE_ABANDONED;
                    st.phase = PH_IDLE;
                    r.speed_reported = confirm_speed(st, raw);
                    st.timer = (st.cfg.sample_ticks <= 16'd1) ? 16'd0 : 16'd1;
                end else begin
                    st.phase = PH_HIGH;
                    st.timer = 16'd1;
                end
            end
        end else begin
            st.phase = PH_IDLE;
            if (st.timer == 16'd0) begin
                started = 1'b0;
                if (st.fill != 4'd0) begin
                    want = st.fifo[st.head];
                    st.head = st.head + 3'd1;
                    st.fill = st.fill - 4'd1;
                    if (want != st.confirmed) begin
                        st.target = want;
                        st.next_due = raw + 2'd1;
                        st.misses = 4'd0;
                        st.phase = PH_HIGH;
                        st.timer = 16'd1;
                        started = 1'b1;
                    end
                end
                if (!started) r.speed_reported = confirm_speed(st, raw);
            end
            if (st.phase == PH_IDLE) begin
                st.timer = st.timer + 16'd1;
                if (st.timer >= st.cfg.sample_ticks) st.timer = 16'd0;
            end
        end
        r.relay_level = (st.phase == PH_HIGH);
        r.current_speed = st.confirmed;
        return r;
    endfunction

    function automatic logic stall_now(input int mode, input logic sender);
        int pct;
        if (mode == MODE_FREE) return 1'b0;
        pct = ((mode == MODE_RX_STALLS) == sender) ? 26 : 77;
        return $urandom_range(99) < pct;
    endfunction

    function automatic item_t tick_with(input logic [2:0] leds);
        item_t it;
        it.action = 1'b0;
        it.data.requested_speed = 8'($urandom_range(255));
        it.data.led_low = leds[0];
        it.data.led_mid = leds[1];
        it.data.led_high = leds[2];
        return it;
    endfunction

    // The indicators follow the simulated fan; the lower ones are sometimes lit as well,
    // and now and then the levels are plain noise.
    function automatic item_t fan_tick();
        logic [2:0] leds;
        int k;
        leds = 3'b111;
        if ($urandom_range(99) < 6) begin
            leds = 3'($urandom_range(7));
        end else if (fan_speed != 2'd0) begin
            leds[fan_speed - 2'd1] = 1'b0;
            for (k = 0; k < int'(fan_speed) - 1; k++) leds[k] = 1'($urandom_range(1));
        end
        return tick_with(leds);
    endfunction

    function automatic item_t speed_request(input logic [7:0] value);
        item_t it;
        it = tick_with(3'($urandom_range(7)));
        it.action = 1'b1;
        it.data.requested_speed = value;
        return it;
    endfunction

    function automatic logic [7:0] pick_speed();
        return ($urandom_range(9) < 7) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    endfunction

    // The fan steps on each rising relay edge, but misses a step now and then.
    task automatic queue_item(input item_t it);
        logic was_high;
        result_t r;
        was_high = (plan_ctrl.phase == PH_HIGH);
        r = fan_ctrl_step(plan_ctrl, it);
        if (!was_high && r.relay_level && $urandom_range(9) != 0) fan_speed = fan_speed + 2'd1;
        items_waiting.push_back(it);
    endtask

    task automatic random_items(input int n);
        int i;
        int j;
        i = 0;
        while (i < n) begin
            if ($urandom_range(99) < 2) begin
                for (j = 0; j < 10; j++) queue_item(speed_request(pick_speed()));
                i += 10;
            end else if ($urandom_range(99) < 10) begin
                queue_item(speed_request(pick_speed()));
                i++;
            end else begin
                queue_item(fan_tick());
                i++;
            end
        end
    endtask

    task automatic drain();
        while (items_waiting.size() != 0 || s_tvalid || results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            CFG_SAMPLE_TICKS: begin
                live_ctrl.cfg.sample_ticks = value;
                plan_ctrl.cfg.sample_ticks = value;
            end
            CFG_PULSE_TICKS: begin
                live_ctrl.cfg.pulse_ticks = value;
                plan_ctrl.cfg.pulse_ticks = value;
            end
            default: begin
                live_ctrl.cfg.max_errors = value[3:0];
                plan_ctrl.cfg.max_errors = value[3:0];
            end
        endcase
    endtask

    task automatic run_phase(input logic [15:0] sample, input logic [15:0] pulse,
                             input logic [15:0] errors, input int n, input int mode);
        drain();
        write_reg(CFG_SAMPLE_TICKS, sample);
        write_reg(CFG_PULSE_TICKS, pulse);
        write_reg(CFG_MAX_ERRORS, errors);
        cfg_wr_en <= 1'b0;
        traffic_mode = mode;
        random_items(n);
    endtask

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) results_due.push_back(fan_ctrl_step(live_ctrl, item_on_bus));
            if (!s_tvalid || s_tready) begin
                if (items_waiting.size() != 0 && !stall_now(traffic_mode, 1'b1)) begin
                    item_on_bus = items_waiting.pop_front();
                    s_tdata <= 16'(item_on_bus.data);
                    s_tuser <= item_on_bus.action;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !stall_now(traffic_mode, 1'b0);
            if (m_tvalid && m_tready) begin
                seen_result = result_t'(m_tdata);
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result transfer %h with nothing outstanding",
                                 $realtime, m_tdata);
                    end
                end else begin
                    due_result = results_due.pop_front();
                    if (seen_result !== due_result) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                                     $realtime,
                                     due_result.relay_level, due_result.current_speed,
                                     due_result.speed_reported, due_result.move_status,
                                     due_result.request_status, seen_result.relay_level,
                                     seen_result.current_speed, seen_result.speed_reported,
                                     seen_result.move_status, seen_result.request_status);
                        end
                    end
                end
            end
        end
    end

    initial begin
        int i;
        live_ctrl = ctrl_after_reset();
        plan_ctrl = ctrl_after_reset();
        fan_speed = 2'd0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: first sample event, clamping, an equal request, a full queue,
        // and every indicator pattern.
        queue_item(tick_with(3'b111));
        queue_item(speed_request(8'd0));
        queue_item(speed_request(8'd255));
        queue_item(speed_request(8'd1));
        queue_item(speed_request(8'd2));
        queue_item(speed_request(8'd3));
        queue_item(speed_request(8'd1));
        queue_item(speed_request(8'd2));
        queue_item(speed_request(8'd3));
        queue_item(speed_request(8'd1));
        queue_item(speed_request(8'd2));
        for (i = 0; i < 8; i++) queue_item(tick_with(3'(i)));

        run_phase(16'd1, 16'd1, 16'd3, 60, MODE_RX_STALLS);
        run_phase(16'd3, 16'd2, 16'd1, 60, MODE_RX_STALLS);
        run_phase(16'd0, 16'd0, 16'd0, 40, MODE_RX_STALLS);
        run_phase(16'd2, 16'd1, 16'd15, 60, MODE_TX_GAPS);
        run_phase(16'd5, 16'd3, 16'd2, 60, MODE_TX_GAPS);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 15, MODE_TX_GAPS);
        run_phase(16'd4, 16'd2, 16'd4, 40, MODE_TX_GAPS);
        run_phase(16'd1, 16'd3, 16'd3, 60, MODE_FREE);
        run_phase(16'd2, 16'd2, 16'd5, 60, MODE_FREE);
        drain();

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
